>>> rtl/pfx_pkg.sv
package pfx_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 9;

    localparam int CHAR_W   = 8;
    localparam int OUT_W    = 32;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_UNDER = 3'd2;
    localparam t_status ST_OVER  = 3'd3;
    localparam t_status ST_DIV0  = 3'd4;
    localparam t_status ST_LONG  = 3'd5;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

endpackage

>>> rtl/pfx_ram.sv
module pfx_ram #(
    parameter int WIDTH = pfx_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pfx_alu.sv
module pfx_alu #(
    parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pfx_pkg::t_alu_ctl      i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_op_a,
    input  logic [VALUE_WIDTH-1:0] i_op_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_result
);

    import pfx_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_ONE  = 6'b000010,
        A_NEGA = 6'b000100,
        A_NEGB = 6'b001000,
        A_STEP = 6'b010000,
        A_FIX  = 6'b100000
    } t_alu_state;

    t_alu_state      r_state;
    t_alu_op         r_op;
    logic [W-1:0]    r_a;      // multiplicand, or dividend shifting into quotient
    logic [W-1:0]    r_b;      // multiplier, or divisor magnitude
    logic [W-1:0]    r_acc;    // product accumulator, or partial remainder
    logic [W-1:0]    r_res;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic            r_done;

    // shared adder/subtractor
    logic [W:0]      add_x;
    logic [W:0]      add_y;
    logic            add_inv;
    logic [W+1:0]    add_sum;
    logic            last_step;

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_inv = 1'b0;
        unique case (r_state)
            A_ONE: begin
                add_x   = {1'b0, r_a};
                add_y   = {1'b0, r_b};
                add_inv = (r_op == OP_SUB);
            end
            A_NEGA: begin
                add_y   = {1'b0, r_a};
                add_inv = 1'b1;
            end
            A_NEGB: begin
                add_y   = {1'b0, r_b};
                add_inv = 1'b1;
            end
            A_STEP: begin
                if (r_op == OP_MUL) begin
                    add_x = {1'b0, r_acc};
                    add_y = r_b[0] ? {1'b0, r_a} : '0;
                end else begin
                    add_x   = {r_acc, r_a[W-1]};
                    add_y   = {1'b0, r_b};
                    add_inv = 1'b1;
                end
            end
            A_FIX: begin
                add_y   = {1'b0, r_a};
                add_inv = 1'b1;
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    // bit W+1 is the no-borrow flag when subtracting
    assign add_sum   = {1'b0, add_x} + {1'b0, (add_inv ? ~add_y : add_y)}
                     + {{(W+1){1'b0}}, add_inv};
    assign last_step = (r_cnt == CW'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_ctl.start) begin
                        unique case (i_ctl.op)
                            OP_DIV:  r_state <= A_NEGA;
                            OP_MUL:  r_state <= A_STEP;
                            default: r_state <= A_ONE;
                        endcase
                    end
                end
                A_ONE: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_NEGA: r_state <= A_NEGB;
                A_NEGB: r_state <= A_STEP;
                A_STEP: begin
                    if (last_step) begin
                        if (r_op == OP_MUL) begin
                            r_done  <= 1'b1;
                            r_state <= A_IDLE;
                        end else begin
                            r_state <= A_FIX;
                        end
                    end
                end
                A_FIX: begin
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_ctl.start) begin
                    r_op  <= i_ctl.op;
                    r_a   <= i_op_a;
                    r_b   <= i_op_b;
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_neg <= i_op_a[W-1] ^ i_op_b[W-1];
                end
            end
            A_ONE: r_res <= add_sum[W-1:0];
            A_NEGA: begin
                if (r_a[W-1]) begin
                    r_a <= add_sum[W-1:0];
                end
            end
            A_NEGB: begin
                if (r_b[W-1]) begin
                    r_b <= add_sum[W-1:0];
                end
            end
            A_STEP: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_op == OP_MUL) begin
                    r_acc <= add_sum[W-1:0];
                    r_a   <= r_a << 1;
                    r_b   <= r_b >> 1;
                    if (last_step) begin
                        r_res <= add_sum[W-1:0];
                    end
                end else begin
                    r_acc <= add_sum[W+1] ? add_sum[W-1:0] : add_x[W-1:0];
                    r_a   <= {r_a[W-2:0], add_sum[W+1]};
                end
            end
            A_FIX: r_res <= r_neg ? add_sum[W-1:0] : r_a;
            default: r_res <= r_res;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> rtl/postfix_expression_evaluator.sv
// Postfix (RPN) evaluator, one ASCII character per input transaction. Digits
// build a decimal number; a space, an operator or the last character pushes
// it on the value stack. + - * / pop two entries and push op2 op op1, wrapping
// at VALUE_WIDTH bits, division truncating toward zero. On the character
// marked last one output transaction carries the value and a status (0 ok,
// 1 empty or leftover, 2 underflow, 3 overflow, 4 divide by zero, 5 number too
// long); the first error sticks until then and the block then starts clean.
// Digits, spaces and other characters not marked last are taken with no stall;
// + - * and / stall while the stack RAM's single read port fetches both
// operands and the shared add/subtract unit works, bit by bit for * and /.
// The last character adds the final push and the read of the bottom entry.
// o_stall stays high while an item is in progress.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = pfx_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pfx_pkg::CHAR_W-1:0]   i_char_in,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [pfx_pkg::OUT_W-1:0] o_value,
    output logic [pfx_pkg::STATUS_W-1:0] o_status
);

    import pfx_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int DCW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_OPCHK = 8'b00000010,
        S_RD2   = 8'b00000100,
        S_RD3   = 8'b00001000,
        S_ALU   = 8'b00010000,
        S_FLUSH = 8'b00100000,
        S_FRD   = 8'b01000000,
        S_FOUT  = 8'b10000000
    } t_state;

    t_state           r_state, n_state;
    logic [SCW-1:0]   r_cnt, n_cnt;
    logic [W-1:0]     r_acc, n_acc;
    logic [DCW-1:0]   r_dig, n_dig;
    t_status          r_err, n_err;
    t_alu_op          r_op, n_op;
    logic             r_last, n_last;
    logic [W-1:0]     r_op1, n_op1;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_value, n_out_value;
    t_status          r_out_status, n_out_status;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [W-1:0]     ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [W-1:0]     ram_rdata;

    t_alu_ctl         alu_ctl;
    logic             alu_done;
    logic [W-1:0]     alu_result;

    logic [SCW-1:0]   cnt_m1, cnt_m2;
    logic             full;
    logic             is_digit, is_space, is_oper;
    logic [W-1:0]     acc10;
    logic [OUT_W-1:0] ext_value;
    t_state           after_op;
    t_status          fin_status;

    pfx_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pfx_alu #(
        .VALUE_WIDTH (W)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_op_a   (ram_rdata),
        .i_op_b   (r_op1),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    assign cnt_m1   = r_cnt - SCW'(1);
    assign cnt_m2   = r_cnt - SCW'(2);
    assign full     = (r_cnt == SCW'(STACK_DEPTH));
    assign is_digit = (i_char_in >= CH_ZERO) && (i_char_in <= CH_NINE);
    assign is_space = (i_char_in == CH_SPACE);
    assign is_oper  = (i_char_in == CH_PLUS) || (i_char_in == CH_MINUS)
                   || (i_char_in == CH_STAR) || (i_char_in == CH_SLASH);
    // n*10 + d as two shifts and adds
    assign acc10    = (r_acc << 3) + (r_acc << 1) + W'(i_char_in - CH_ZERO);
    assign after_op = r_last ? S_FLUSH : S_IDLE;

    always_comb begin
        for (int i = 0; i < OUT_W; i++) begin
            ext_value[i] = ram_rdata[(i < W) ? i : (W - 1)];
        end
    end

    always_comb begin
        priority if (r_err != ST_OK) begin
            fin_status = r_err;
        end else if (r_cnt != SCW'(1)) begin
            fin_status = ST_EMPTY;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_dig        = r_dig;
        n_err        = r_err;
        n_op         = r_op;
        n_last       = r_last;
        n_op1        = r_op1;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_cnt[AW-1:0];
        ram_wdata    = r_acc;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = r_op;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last  = i_last;
                    n_state = i_last ? S_FLUSH : S_IDLE;
                    if (r_err == ST_OK) begin
                        if (is_digit) begin
                            if (r_dig >= DCW'(MAX_DIGITS)) begin
                                n_err = ST_LONG;
                            end else begin
                                n_acc = acc10;
                                n_dig = r_dig + 1'b1;
                            end
                        end else if (is_space || is_oper) begin
                            if (r_dig != '0) begin
                                if (full) begin
                                    n_err = ST_OVER;
                                end else begin
                                    ram_we = 1'b1;
                                    n_cnt  = r_cnt + 1'b1;
                                end
                                n_acc = '0;
                                n_dig = '0;
                            end
                            if (is_oper) begin
                                n_state = S_OPCHK;
                                priority if (i_char_in == CH_PLUS) begin
                                    n_op = OP_ADD;
                                end else if (i_char_in == CH_MINUS) begin
                                    n_op = OP_SUB;
                                end else if (i_char_in == CH_STAR) begin
                                    n_op = OP_MUL;
                                end else begin
                                    n_op = OP_DIV;
                                end
                            end
                        end
                    end
                end
            end
            S_OPCHK: begin
                if (r_err != ST_OK) begin
                    n_state = after_op;
                end else if (r_cnt < SCW'(2)) begin
                    n_err   = ST_UNDER;
                    n_state = after_op;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_m1[AW-1:0];
                    n_state   = S_RD2;
                end
            end
            S_RD2: begin
                n_op1     = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = cnt_m2[AW-1:0];
                n_state   = S_RD3;
            end
            S_RD3: begin
                if ((r_op == OP_DIV) && (r_op1 == '0)) begin
                    n_err   = ST_DIV0;
                    n_state = after_op;
                end else begin
                    alu_ctl.start = 1'b1;
                    n_state       = S_ALU;
                end
            end
            S_ALU: begin
                if (alu_done) begin
                    // pop two, push one: the result lands where op2 was
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m2[AW-1:0];
                    ram_wdata = alu_result;
                    n_cnt     = cnt_m1;
                    n_state   = after_op;
                end
            end
            S_FLUSH: begin
                if ((r_err == ST_OK) && (r_dig != '0)) begin
                    if (full) begin
                        n_err = ST_OVER;
                    end else begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                    end
                end
                n_acc   = '0;
                n_dig   = '0;
                n_state = S_FRD;
            end
            S_FRD: begin
                ram_re  = 1'b1;
                n_state = S_FOUT;
            end
            S_FOUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = fin_status;
                    n_out_value  = (fin_status == ST_OK) ? ext_value : '0;
                    n_cnt        = '0;
                    n_acc        = '0;
                    n_dig        = '0;
                    n_err        = ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_dig       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_dig       <= n_dig;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_last       <= n_last;
        r_op1        <= n_op1;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

endmodule

>>> rtl/pfx_checker.sv
module pfx_assertions (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_last,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [pfx_pkg::OUT_W-1:0] o_value,
    input logic [pfx_pkg::STATUS_W-1:0] o_status
);

    import pfx_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    // failed expressions report a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_value == '0))
        else $error("nonzero value with error status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_LONG))
        else $error("status code out of range");

    // the final character always needs the closing sequence
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("ready right after last character");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator pfx_assertions u_pfx_checker (.*);
